>>> src/arx_pkg.sv
// Package for the ARX model step: widths, register indexes and payload types.
`timescale 1ns / 1ps
`default_nettype none

package arx_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int FRAC_BITS     = 14;
  localparam int DELAY_BITS    = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int NUM_FEED_REGS = 4;
  localparam int NUM_BACK_REGS = 3;

  localparam int FEED_TAPS_DEF = 4;
  localparam int BACK_TAPS_DEF = 3;
  localparam int MAX_DELAY_DEF = 15;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FEED_BASE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BACK_BASE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY     = 3'd7;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] input_sample;
    logic signed [SAMPLE_BITS-1:0] noise_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] output_sample;
    logic                          saturated;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/arx_cfg_regs.sv
// Configuration registers: feed and feedback coefficients and the input delay.
`timescale 1ns / 1ps
`default_nettype none

module arx_cfg_regs import arx_pkg::*; #(
  parameter int FEED_TAPS = FEED_TAPS_DEF,
  parameter int BACK_TAPS = BACK_TAPS_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  localparam int KW = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output coef_t                    feed_coef_o [FEED_TAPS],
  output coef_t                    back_coef_o [BACK_TAPS],
  output logic [KW-1:0]            delay_o
);

  coef_t                 feed_q [FEED_TAPS];
  coef_t                 back_q [BACK_TAPS];
  logic [DELAY_BITS-1:0] delay_q;

  // Only the first NUM_FEED_REGS / NUM_BACK_REGS coefficients have an index.
  for (genvar i = 0; i < FEED_TAPS; i++) begin : g_feed
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        feed_q[i] <= '0;
      end else if (cfg_we_i && (i < NUM_FEED_REGS) &&
                   (cfg_idx_i == CFG_FEED_BASE + CFG_IDX_BITS'(i))) begin
        feed_q[i] <= coef_t'(cfg_data_i[COEF_BITS-1:0]);
      end
    end
    assign feed_coef_o[i] = feed_q[i];
  end

  for (genvar j = 0; j < BACK_TAPS; j++) begin : g_back
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        back_q[j] <= '0;
      end else if (cfg_we_i && (j < NUM_BACK_REGS) &&
                   (cfg_idx_i == CFG_BACK_BASE + CFG_IDX_BITS'(j))) begin
        back_q[j] <= coef_t'(cfg_data_i[COEF_BITS-1:0]);
      end
    end
    assign back_coef_o[j] = back_q[j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_DELAY)) begin
      delay_q <= cfg_data_i[DELAY_BITS-1:0];
    end
  end

  // A programmed delay beyond the line length is held at the longest one.
  always_comb begin
    if (int'(delay_q) > MAX_DELAY) begin
      delay_o = KW'(MAX_DELAY);
    end else begin
      delay_o = KW'(delay_q);
    end
  end

endmodule

`default_nettype wire

>>> src/arx_in_hist.sv
// Input delay line with per-tap selection by the transport delay.
`timescale 1ns / 1ps
`default_nettype none

module arx_in_hist import arx_pkg::*; #(
  parameter int FEED_TAPS = FEED_TAPS_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF,
  localparam int KW = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  sample_t       sample_i,
  input  logic [KW-1:0] delay_i,
  output sample_t       taps_o [FEED_TAPS]
);

  localparam int HIST_DEPTH = FEED_TAPS + MAX_DELAY;
  localparam int PAST_DEPTH = (HIST_DEPTH > 1) ? HIST_DEPTH - 1 : 1;
  localparam int WIN_BITS   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  // Past samples, newest first; the current sample is not yet stored.
  sample_t past_q [PAST_DEPTH];
  sample_t win    [HIST_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < PAST_DEPTH; n++) begin
        past_q[n] <= '0;
      end
    end else if (shift_i) begin
      past_q[0] <= sample_i;
      for (int n = 1; n < PAST_DEPTH; n++) begin
        past_q[n] <= past_q[n-1];
      end
    end
  end

  always_comb begin
    win[0] = sample_i;
    for (int n = 1; n < HIST_DEPTH; n++) begin
      win[n] = past_q[n-1];
    end
  end

  for (genvar i = 0; i < FEED_TAPS; i++) begin : g_tap
    logic [WIN_BITS-1:0] sel;
    assign sel       = WIN_BITS'(delay_i) + WIN_BITS'(i);
    assign taps_o[i] = win[sel];
  end

endmodule

`default_nettype wire

>>> src/arx_mac.sv
// Products, wide sum, round to nearest and saturation for one output sample.
`timescale 1ns / 1ps
`default_nettype none

module arx_mac import arx_pkg::*; #(
  parameter int FEED_TAPS = FEED_TAPS_DEF,
  parameter int BACK_TAPS = BACK_TAPS_DEF
) (
  input  sample_t   taps_i      [FEED_TAPS],
  input  coef_t     feed_coef_i [FEED_TAPS],
  input  sample_t   y_hist_i    [BACK_TAPS],
  input  coef_t     back_coef_i [BACK_TAPS],
  input  sample_t   noise_i,
  output out_item_t result_o
);

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + $clog2(FEED_TAPS + BACK_TAPS + 1) + 1;
  localparam int SH_BITS   = ACC_BITS - FRAC_BITS;

  localparam logic signed [SH_BITS-1:0] Y_MAX = SH_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SH_BITS-1:0] Y_MIN = -Y_MAX - SH_BITS'(1);

  logic signed [PROD_BITS-1:0] feed_prod [FEED_TAPS];
  logic signed [PROD_BITS-1:0] back_prod [BACK_TAPS];
  logic signed [ACC_BITS-1:0]  noise_ext;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  rounded;
  logic signed [SH_BITS-1:0]   shifted;

  for (genvar i = 0; i < FEED_TAPS; i++) begin : g_fp
    assign feed_prod[i] = taps_i[i] * feed_coef_i[i];
  end

  for (genvar j = 0; j < BACK_TAPS; j++) begin : g_bp
    assign back_prod[j] = y_hist_i[j] * back_coef_i[j];
  end

  always_comb begin
    noise_ext = ACC_BITS'(noise_i);
    acc       = noise_ext <<< FRAC_BITS;
    for (int i = 0; i < FEED_TAPS; i++) begin
      acc = acc + ACC_BITS'(feed_prod[i]);
    end
    for (int j = 0; j < BACK_TAPS; j++) begin
      acc = acc - ACC_BITS'(back_prod[j]);
    end
    // Half an LSB is added so that ties round toward plus infinity.
    rounded = acc + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
    shifted = SH_BITS'(rounded >>> FRAC_BITS);

    if (shifted > Y_MAX) begin
      result_o.output_sample = Y_MAX[SAMPLE_BITS-1:0];
      result_o.saturated     = 1'b1;
    end else if (shifted < Y_MIN) begin
      result_o.output_sample = Y_MIN[SAMPLE_BITS-1:0];
      result_o.saturated     = 1'b1;
    end else begin
      result_o.output_sample = shifted[SAMPLE_BITS-1:0];
      result_o.saturated     = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/arx_model_step.sv
// Top level of the ARX plant model step: handshake, stage registers, output history.
`timescale 1ns / 1ps
`default_nettype none

// ARX plant model, one step per input transaction.
// Each input transaction carries a plant input sample and a noise sample; each
// produces exactly one output transaction with the rounded, saturated model
// output and a flag that tells whether it was clipped.
// Both channels use valid/stall: a transaction completes on a rising edge with
// valid high and stall low. Coefficients and the transport delay are written
// through the plain write port (enable, index, data); the user must write them
// only while the block is idle, which the block does not enforce. Output
// valid rises when the multiply-accumulate, rounding and saturation of the
// staged input land in the result register; a stalled result still waiting
// there holds this back. While the receiver does not stall, throughput is one
// transaction per cycle, limited by the feedback loop through the output
// history. The result register is a separate stage, so a new input is taken
// while a finished result still waits. When the receiver stalls, the result
// holds and the input register fills; only then does the input side stall.
// Reset (asynchronous, active low) clears all coefficients, the delay, both
// sample histories and all valid flags.
module arx_model_step import arx_pkg::*; #(
  parameter int FEED_TAPS = FEED_TAPS_DEF,
  parameter int BACK_TAPS = BACK_TAPS_DEF,
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int KW = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1;

  coef_t         feed_coef [FEED_TAPS];
  coef_t         back_coef [BACK_TAPS];
  logic [KW-1:0] delay;
  sample_t       taps      [FEED_TAPS];
  out_item_t     result;

  // Input stage register.
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_data_q;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  // Output history, newest first.
  sample_t y_hist_q [BACK_TAPS];

  logic advance;
  logic in_accept;

  // The input stage moves on when the result register is empty or being taken.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  // The clipped value is what feeds back into later steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < BACK_TAPS; j++) begin
        y_hist_q[j] <= '0;
      end
    end else if (advance) begin
      y_hist_q[0] <= result.output_sample;
      for (int j = 1; j < BACK_TAPS; j++) begin
        y_hist_q[j] <= y_hist_q[j-1];
      end
    end
  end

  arx_cfg_regs #(
    .FEED_TAPS (FEED_TAPS),
    .BACK_TAPS (BACK_TAPS),
    .MAX_DELAY (MAX_DELAY)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .feed_coef_o (feed_coef),
    .back_coef_o (back_coef),
    .delay_o     (delay)
  );

  // The delay line shifts in the staged sample as its step completes.
  arx_in_hist #(
    .FEED_TAPS (FEED_TAPS),
    .MAX_DELAY (MAX_DELAY)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (advance),
    .sample_i (s1_data_q.input_sample),
    .delay_i  (delay),
    .taps_o   (taps)
  );

  arx_mac #(
    .FEED_TAPS (FEED_TAPS),
    .BACK_TAPS (BACK_TAPS)
  ) u_mac (
    .taps_i      (taps),
    .feed_coef_i (feed_coef),
    .y_hist_i    (y_hist_q),
    .back_coef_i (back_coef),
    .noise_i     (s1_data_q.noise_sample),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> tb/sv/arx_model_step_tb.sv
// Self-checking testbench for the ARX model step with its own output predictor.
`timescale 1ns / 1ps

// The testbench drives input transactions through the valid/stall handshake,
// predicts every output transaction with a fixed-point model of the filter and
// compares each result, field by field, against the oldest prediction.
// Coefficients and the transport delay are changed only while the block is
// idle. A directed section covers full-scale samples, rounding ties and
// clipping in both directions. It is followed by random sections, each with
// its own filter setting. The sender works in bursts and the receiver stalls
// on a pattern of its own. Once the receiver holds off long enough that the
// block must stall its input. Once the sender waits until every result is back.
module arx_model_step_tb;
  import arx_pkg::*;

  localparam int HIST_LEN        = FEED_TAPS_DEF + MAX_DELAY_DEF;
  localparam longint SAMPLE_MAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
  localparam int RAND_SECTIONS   = 8;
  localparam int ITEMS_PER_SECT  = 200;
  localparam int HOLD_CYCLES     = 64;
  localparam int TAIL_CYCLES     = 8;
  localparam int IDLE_LIMIT      = 2000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;
  typedef enum int {STYLE_STABLE, STYLE_FULL, STYLE_GENTLE, STYLE_SPARSE} coef_style_e;

  // Predictor of the filter plus the store of predicted output transactions.
  class arx_output_checker;
    coef_t                  feed_coef [FEED_TAPS_DEF];
    coef_t                  back_coef [BACK_TAPS_DEF];
    logic [DELAY_BITS-1:0]  delay;
    sample_t                in_hist   [HIST_LEN];
    sample_t                out_hist  [BACK_TAPS_DEF];
    out_item_t              predicted_q [$];
    int                     mismatches;
    int                     checked;
    int                     clipped;

    function new();
      foreach (feed_coef[i]) feed_coef[i] = '0;
      foreach (back_coef[i]) back_coef[i] = '0;
      foreach (in_hist[i]) in_hist[i] = '0;
      foreach (out_hist[i]) out_hist[i] = '0;
      delay      = '0;
      mismatches = 0;
      checked    = 0;
      clipped    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx < CFG_BACK_BASE) begin
        feed_coef[idx - CFG_FEED_BASE] = coef_t'(data);
      end else if (idx < CFG_DELAY) begin
        back_coef[idx - CFG_BACK_BASE] = coef_t'(data);
      end else if (idx == CFG_DELAY) begin
        delay = data[DELAY_BITS-1:0];
      end
    endfunction

    // Advances the filter by one accepted input transaction and queues the result.
    function void take_input(in_item_t item);
      longint    acc;
      longint    y;
      out_item_t pred;
      for (int i = HIST_LEN - 1; i > 0; i--) in_hist[i] = in_hist[i-1];
      in_hist[0] = item.input_sample;
      acc = longint'(item.noise_sample) * (longint'(1) << FRAC_BITS);
      for (int i = 0; i < FEED_TAPS_DEF; i++)
        acc += longint'(feed_coef[i]) * longint'(in_hist[int'(delay) + i]);
      for (int j = 0; j < BACK_TAPS_DEF; j++)
        acc -= longint'(back_coef[j]) * longint'(out_hist[j]);
      // Round half up, then an arithmetic shift floors the scaled sum.
      y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      pred.saturated = 1'b0;
      if (y > SAMPLE_MAX) begin
        y = SAMPLE_MAX;
        pred.saturated = 1'b1;
      end
      if (y < SAMPLE_MIN) begin
        y = SAMPLE_MIN;
        pred.saturated = 1'b1;
      end
      pred.output_sample = sample_t'(y);
      for (int j = BACK_TAPS_DEF - 1; j > 0; j--) out_hist[j] = out_hist[j-1];
      out_hist[0] = pred.output_sample;
      predicted_q.insert(predicted_q.size(), pred);
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (predicted_q.size() == 0) begin
        $error("output transaction with no prediction waiting: output_sample %0d",
               got.output_sample);
        mismatches++;
        return;
      end
      want = predicted_q.pop_front();
      checked++;
      if (want.saturated) clipped++;
      if (got.output_sample !== want.output_sample) begin
        $error("output_sample: expected %0d, actual %0d", want.output_sample,
               got.output_sample);
        mismatches++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  in_item_t                 in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  out_item_t                out_data_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  arx_output_checker chk = new();

  // Filter setting that load_filter writes into the block.
  coef_t                 feed_set [FEED_TAPS_DEF];
  coef_t                 back_set [BACK_TAPS_DEF];
  logic [DELAY_BITS-1:0] delay_set;

  bit hold_req;
  int holds_done;
  int rcv_cycle;
  int idle_cycles;
  int settings_used;

  arx_model_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every output transaction is checked at the edge where it completes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_output(out_data_o);
  end

  // The watchdog ends the run when no transaction completes on either channel
  // for a long time. The longest legal quiet stretch is the receiver hold.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, chk.outstanding());
        $display("arx_model_step_tb: done, errors");
        $finish;
      end
    end
  end

  // The receiver cycles through stall modes window by window: no stalls,
  // light random stalls, heavy random stalls and a fixed rhythm. When
  // the sender asks for a hold, the receiver stalls for a counted stretch.
  initial begin : receiver
    out_stall_i = 1'b0;
    rcv_cycle   = 0;
    holds_done  = 0;
    forever begin
      @(negedge clk_i);
      rcv_cycle++;
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      case (stall_mode_e'((rcv_cycle / 300) % 4))
        STALL_NONE:     out_stall_i = 1'b0;
        STALL_LIGHT:    out_stall_i = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall_i = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall_i = ((rcv_cycle % 7) < 3);
        default:        out_stall_i = 1'b0;
      endcase
    end
  end

  function automatic in_item_t pair(int u, int e);
    in_item_t item;
    item.input_sample = sample_t'(u);
    item.noise_sample = sample_t'(e);
    return item;
  endfunction

  // Mostly full-scale samples, now and then small ones so that stable filter
  // settings also produce outputs that stay inside the range.
  function automatic sample_t rand_sample();
    if ($urandom_range(0, 3) == 0) return sample_t'(int'($urandom_range(0, 512)) - 256);
    return sample_t'($urandom);
  endfunction

  function automatic coef_t rand_coef(int span);
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Offers one input transaction and returns at the edge where it completes.
  // The valid stays high, so back-to-back calls send without a gap.
  task automatic offer(input in_item_t item);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = item;
    do @(posedge clk_i); while (in_stall_o);
    chk.take_input(item);
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (chk.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CFG_IDX_BITS'(idx);
    cfg_data_i = data;
    @(posedge clk_i);
    chk.write_reg(CFG_IDX_BITS'(idx), data);
  endtask

  // Writes the whole setting once the block has delivered every result and
  // the pipeline has had time to settle.
  task automatic load_filter();
    wait_drained();
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < FEED_TAPS_DEF; i++) write_reg(int'(CFG_FEED_BASE) + i, feed_set[i]);
    for (int j = 0; j < BACK_TAPS_DEF; j++) write_reg(int'(CFG_BACK_BASE) + j, back_set[j]);
    write_reg(int'(CFG_DELAY), CFG_DATA_BITS'(delay_set));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    settings_used++;
  endtask

  // Picks a random filter setting; the style decides how large the
  // coefficients may be and so how often the output clips.
  task automatic pick_setting(input coef_style_e style);
    for (int i = 0; i < FEED_TAPS_DEF; i++) begin
      case (style)
        STYLE_STABLE: feed_set[i] = rand_coef(8192);
        STYLE_FULL:   feed_set[i] = coef_t'($urandom);
        STYLE_GENTLE: feed_set[i] = rand_coef(4096);
        default:      feed_set[i] = $urandom_range(0, 1) ? coef_t'($urandom) : '0;
      endcase
    end
    for (int j = 0; j < BACK_TAPS_DEF; j++) begin
      case (style)
        STYLE_STABLE: back_set[j] = rand_coef(4096);
        STYLE_FULL:   back_set[j] = coef_t'($urandom);
        STYLE_GENTLE: back_set[j] = rand_coef(2048);
        default:      back_set[j] = $urandom_range(0, 1) ? coef_t'($urandom) : '0;
      endcase
    end
    delay_set = DELAY_BITS'($urandom_range(0, MAX_DELAY_DEF));
  endtask

  initial begin : sender
    int burst;
    int sent;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    hold_req      = 1'b0;
    settings_used = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unity gain on the newest input: samples pass straight through, the
    // noise adds on top, and full-scale sums clip high and low.
    feed_set  = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
    back_set  = '{16'sd0, 16'sd0, 16'sd0};
    delay_set = '0;
    load_filter();
    offer(pair(32767, 0));
    offer(pair(-32768, 0));
    offer(pair(0, 32767));
    offer(pair(0, -32768));
    offer(pair(32767, 32767));
    offer(pair(-32768, -32768));
    offer(pair(1, 0));

    // Gain of one half puts odd inputs exactly on a rounding tie, which must
    // go toward plus infinity for both signs.
    feed_set[0] = 16'sd8192;
    load_filter();
    offer(pair(1, 0));
    offer(pair(-1, 0));
    offer(pair(3, 0));
    offer(pair(-3, 0));

    // Most negative input gains, largest feedback gains and the longest delay.
    // The old samples in the delay line still count here.
    feed_set  = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
    back_set  = '{16'sd32767, 16'sd32767, 16'sd32767};
    delay_set = DELAY_BITS'(MAX_DELAY_DEF);
    load_filter();
    offer(pair(32767, 32767));
    offer(pair(-32768, -32768));
    offer(pair(32767, 0));
    offer(pair(-32768, 32767));
    offer(pair(0, -32768));
    offer(pair(-1, 1));

    // The opposite extremes with no delay.
    feed_set  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
    back_set  = '{-16'sd32768, -16'sd32768, -16'sd32768};
    delay_set = '0;
    load_filter();
    offer(pair(32767, 32767));
    offer(pair(-32768, -32768));
    offer(pair(32767, -32768));
    offer(pair(0, 0));
    offer(pair(-1, 1));

    // Random sections. The first runs with no delay and the last with the
    // longest one. The third asks the receiver for a long hold. The sixth
    // pauses until every result has come back.
    for (int sect = 0; sect < RAND_SECTIONS; sect++) begin
      pick_setting(coef_style_e'(sect % 4));
      if (sect == 0) delay_set = '0;
      if (sect == RAND_SECTIONS - 1) delay_set = DELAY_BITS'(MAX_DELAY_DEF);
      load_filter();
      sent = 0;
      while (sent < ITEMS_PER_SECT) begin
        burst = $urandom_range(1, 48);
        for (int n = 0; n < burst && sent < ITEMS_PER_SECT; n++) begin
          if (sect == 2 && sent == 40) hold_req = 1'b1;
          if (sect == 5 && sent == 100) wait_drained();
          offer(pair(rand_sample(), rand_sample()));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d output transactions, %0d of them clipped, over %0d filter settings",
             chk.checked, chk.clipped, settings_used);
    $display("delays 0 and %0d used, %0d long receiver holds", MAX_DELAY_DEF, holds_done);
    if (chk.mismatches == 0) begin
      $display("arx_model_step_tb: done, clean");
    end else begin
      $display("arx_model_step_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/arx_pkg.sv
src/arx_cfg_regs.sv
src/arx_in_hist.sv
src/arx_mac.sv
src/arx_model_step.sv
tb/sv/arx_model_step_tb.sv
